### hw/rtl/tdsac_pkg.sv
// Shared constants, widths and handshake types of the TDS averaging and conversion block
`default_nettype none

package tdsac_pkg;

    // Ring of recent samples
    localparam int AVG_DEPTH = 16;
    localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

    // Field widths
    localparam int MV_W   = 12;
    localparam int TEMP_W = 15;
    localparam int PPM_W  = 15;

    localparam int MV_LIMIT = 3300;
    localparam int MV_PER_V = 1000;
    localparam int SUM_W    = $clog2(AVG_DEPTH * MV_LIMIT + 1);
    localparam int CNT_W    = $clog2(AVG_DEPTH + 1);

    // Q16 voltage and its powers
    localparam int FRAC_W = 16;
    localparam int V_W    = 18;
    localparam int V2_W   = 20;
    localparam int V3_W   = 22;

    // Shared multiplier
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Polynomial and compensation
    localparam int POLY_W  = 46;
    localparam int SPLIT_W = POLY_W / 2;
    localparam int COMP_W  = 12;
    localparam int LO_W    = SPLIT_W + COMP_W;
    localparam int N_W     = 57;
    localparam int SHIFT_W = 32;
    localparam int RAW_W   = N_W - SHIFT_W;
    localparam int DEN_W   = TEMP_W + 2;

    localparam logic [MUL_A_W-1:0] COEF3 = MUL_A_W'(8743813);
    localparam logic [MUL_A_W-1:0] COEF2 = MUL_A_W'(16768041);
    localparam logic [MUL_A_W-1:0] COEF1 = MUL_A_W'(56189911);
    localparam logic [MUL_B_W-1:0] MULT_MV_PER_V = MUL_B_W'(MV_PER_V);
    localparam logic [MUL_B_W-1:0] MULT_COMP     = MUL_B_W'(2500);
    localparam logic signed [DEN_W-1:0] TEMP_OFFSET = DEN_W'(2500);
    localparam logic [RAW_W-1:0] RAW_SAT = RAW_W'(32767);

    // Shared divider
    localparam int DEN_Q_W   = $clog2(AVG_DEPTH * MV_PER_V + 1);
    localparam int DIV_NW    = (SUM_W + FRAC_W > RAW_W) ? SUM_W + FRAC_W : RAW_W;
    localparam int DIV_DW    = (DEN_Q_W > TEMP_W) ? DEN_Q_W : TEMP_W;
    localparam int DIV_CNT_W = $clog2(DIV_NW);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PPM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PPM = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

### hw/rtl/tds_sensor_average_and_convert_top.sv
// Top level: sample ring, moving average and cubic ppm conversion with temperature compensation
//
//  channel  direction  handshake           payload
//  -------  ---------  ------------------  ---------------------------------------------
//  input    in         i_valid / o_stall   i_sample_mv, i_temperature_centi
//  result   out        o_valid / i_stall   o_tds_ppm, o_average_mv, o_sample_rejected
//  config   in         i_cfg_we            i_cfg_idx, i_cfg_wdata (min_ppm, max_ppm)
//
// A word runs a pass over the 16 ring entries, three runs of the shared 32-step divider
// (average, Q16 volts, compensation), 11 steps on the shared multiplier and one to load the
// result. A rejected word skips the ring pass and the first two divisions, an empty ring the
// first two divisions; a zero or negative compensation divisor drops the last division.
// Reset (synchronous, active low) clears the ring, the write pointer and the limits to 0 / 1000.
// o_stall is high from acceptance until the result is loaded; a loaded result waits under
// i_stall while the next word is already taken.
`default_nettype none

module tds_sensor_average_and_convert_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [tdsac_pkg::MV_W-1:0]          i_sample_mv,
    input  wire logic signed [tdsac_pkg::TEMP_W-1:0] i_temperature_centi,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [tdsac_pkg::PPM_W-1:0]              o_tds_ppm,
    output logic [tdsac_pkg::MV_W-1:0]               o_average_mv,
    output logic                                     o_sample_rejected,
    input  wire logic                                i_cfg_we,
    input  wire logic [tdsac_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tdsac_pkg::PPM_W-1:0]         i_cfg_wdata
);
    import tdsac_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SUM, S_AVG_GO, S_AVG_WAIT, S_V_GO, S_V_WAIT,
        S_SQ, S_V2, S_CUBE, S_V3, S_T3, S_T1, S_T2, S_LO,
        S_MLO, S_MHI, S_NSUM, S_RAW_GO, S_RAW_WAIT, S_DONE
    } t_state;

    // Control state
    t_state            r_state;
    logic [MV_W-1:0]   r_ring [AVG_DEPTH];
    logic [IDX_W-1:0]  r_wr_idx;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic [PPM_W-1:0]  r_min_ppm;
    logic [PPM_W-1:0]  r_max_ppm;
    logic              r_out_valid;
    logic [PPM_W-1:0]  r_out_ppm;
    logic [MV_W-1:0]   r_out_avg;
    logic              r_out_rej;

    // Datapath
    logic [SUM_W-1:0]          r_sum;
    logic signed [TEMP_W-1:0]  r_temp;
    logic                      r_rej;
    logic [MV_W-1:0]           r_avg;
    logic [V_W-1:0]            r_v;
    logic [V2_W-1:0]           r_v2;
    logic [V3_W-1:0]           r_v3;
    logic [PROD_W-1:0]         r_prod;
    logic [N_W-1:0]            r_acc;
    logic [LO_W-1:0]           r_lo;
    logic                      r_poly_pos;
    logic [RAW_W-1:0]          r_raw;
    logic                      r_use_min;

    logic                  in_accept;
    logic                  rejected;
    logic                  entry_nz;
    logic [SUM_W-1:0]      sum_nxt;
    logic [CNT_W-1:0]      cnt_nxt;
    logic                  mul_en;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic signed [DEN_W-1:0] comp_den;
    logic                  den_pos;
    logic                  den_zero;
    logic                  out_free;
    logic [PPM_W-1:0]      ppm_clamped;
    t_div_req              div_req;
    t_div_rsp              div_rsp;

    tdsac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign rejected  = (i_sample_mv > MV_W'(MV_LIMIT));
    assign out_free  = !r_out_valid || !i_stall;

    // Ring pass: count nonzero entries only
    assign entry_nz = (r_ring[r_rd_idx] != '0);
    assign sum_nxt  = r_sum + (entry_nz ? SUM_W'(r_ring[r_rd_idx]) : '0);
    assign cnt_nxt  = r_cnt + (entry_nz ? CNT_W'(1) : '0);

    // Compensation divisor: 2500 + T, since 1 + 0.02 (T/100 - 25) = (2500 + T) / 5000
    assign comp_den = TEMP_OFFSET + DEN_W'(r_temp);
    assign den_zero = (comp_den == '0);
    assign den_pos  = !comp_den[DEN_W-1] && !den_zero;

    // Shared multiplier operand selection
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_AVG_GO: begin
                mul_a = MUL_A_W'(r_cnt);
                mul_b = MULT_MV_PER_V;
            end
            S_SQ: begin
                mul_a = MUL_A_W'(r_v);
                mul_b = MUL_B_W'(r_v);
            end
            S_CUBE: begin
                mul_a = MUL_A_W'(r_v2);
                mul_b = MUL_B_W'(r_v);
            end
            S_T3: begin
                mul_a = COEF3;
                mul_b = MUL_B_W'(r_v3);
            end
            S_T1: begin
                mul_a = COEF1;
                mul_b = MUL_B_W'(r_v);
            end
            S_T2: begin
                mul_a = COEF2;
                mul_b = MUL_B_W'(r_v2);
            end
            S_MLO: begin
                mul_a = MUL_A_W'(r_acc[SPLIT_W-1:0]);
                mul_b = MULT_COMP;
            end
            S_MHI: begin
                mul_a = MUL_A_W'(r_acc[POLY_W-1:SPLIT_W]);
                mul_b = MULT_COMP;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Shared divider request
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (r_state)
            S_AVG_GO: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(r_sum);
                div_req.den   = DIV_DW'(r_cnt);
            end
            S_V_GO: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'({r_sum, FRAC_W'(0)});
                div_req.den   = r_prod[DIV_DW-1:0];
            end
            S_RAW_GO: begin
                div_req.start = den_pos;
                div_req.num   = DIV_NW'(r_acc[N_W-1:SHIFT_W]);
                div_req.den   = DIV_DW'(comp_den[TEMP_W-1:0]);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Clamp: the lower limit is checked first; when the limits cross, a value at or above min_ppm takes max_ppm
    always_comb begin
        priority if (r_use_min || r_raw < RAW_W'(r_min_ppm)) begin
            ppm_clamped = r_min_ppm;
        end else if (r_raw > RAW_W'(r_max_ppm)) begin
            ppm_clamped = r_max_ppm;
        end else begin
            ppm_clamped = r_raw[PPM_W-1:0];
        end
    end

    // Sequencer, ring, limits and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_cnt       <= '0;
            r_min_ppm   <= '0;
            r_max_ppm   <= PPM_W'(1000);
            r_out_valid <= 1'b0;
            for (int k = 0; k < AVG_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_PPM: r_min_ppm <= i_cfg_wdata;
                    CFG_MAX_PPM: r_max_ppm <= i_cfg_wdata;
                endcase
            end

            // Drop the result once taken; the final step reloads it itself
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (rejected) begin
                            r_state <= S_SQ;
                        end else begin
                            r_ring[r_wr_idx] <= i_sample_mv;
                            r_wr_idx <= (r_wr_idx == IDX_W'(AVG_DEPTH - 1)) ? '0
                                                                            : r_wr_idx + 1'b1;
                            r_rd_idx <= '0;
                            r_cnt    <= '0;
                            r_state  <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    r_cnt <= cnt_nxt;
                    if (r_rd_idx == IDX_W'(AVG_DEPTH - 1)) begin
                        r_rd_idx <= '0;
                        r_state  <= (cnt_nxt == '0) ? S_SQ : S_AVG_GO;
                    end else begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                end
                S_AVG_GO:   r_state <= S_AVG_WAIT;
                S_AVG_WAIT: if (div_rsp.done) r_state <= S_V_GO;
                S_V_GO:     r_state <= S_V_WAIT;
                S_V_WAIT:   if (div_rsp.done) r_state <= S_SQ;
                S_SQ:       r_state <= S_V2;
                S_V2:       r_state <= S_CUBE;
                S_CUBE:     r_state <= S_V3;
                S_V3:       r_state <= S_T3;
                S_T3:       r_state <= S_T1;
                S_T1:       r_state <= S_T2;
                S_T2:       r_state <= S_LO;
                S_LO:       r_state <= S_MLO;
                S_MLO:      r_state <= S_MHI;
                S_MHI:      r_state <= S_NSUM;
                S_NSUM:     r_state <= S_RAW_GO;
                S_RAW_GO:   r_state <= den_pos ? S_RAW_WAIT : S_DONE;
                S_RAW_WAIT: if (div_rsp.done) r_state <= S_DONE;
                S_DONE: begin
                    // Hold until the result register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ppm   <= ppm_clamped;
                        r_out_avg   <= r_avg;
                        r_out_rej   <= r_rej;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Arithmetic datapath registers
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_temp <= i_temperature_centi;
                    r_rej  <= rejected;
                    r_sum  <= '0;
                    r_v    <= '0;
                    r_avg  <= '0;
                end
            end
            S_SUM:      r_sum <= sum_nxt;
            S_AVG_WAIT: if (div_rsp.done) r_avg <= div_rsp.quot[MV_W-1:0];
            S_V_WAIT:   if (div_rsp.done) r_v <= div_rsp.quot[V_W-1:0];
            S_V2:       r_v2 <= r_prod[FRAC_W +: V2_W];
            S_V3:       r_v3 <= r_prod[FRAC_W +: V3_W];
            S_T1:       r_acc <= N_W'(r_prod);
            S_T2:       r_acc <= r_acc + N_W'(r_prod);
            S_LO:       r_acc <= r_acc - N_W'(r_prod);
            S_MLO:      r_poly_pos <= (r_acc != '0);
            S_MHI:      r_lo <= r_prod[LO_W-1:0];
            S_NSUM:     r_acc <= (N_W'(r_prod) << SPLIT_W) + N_W'(r_lo);
            S_RAW_GO: begin
                // Zero divisor saturates a positive value; a negative one floors at min_ppm
                r_use_min <= !den_pos && !den_zero;
                r_raw     <= (den_zero && r_poly_pos) ? RAW_SAT : '0;
            end
            S_RAW_WAIT: if (div_rsp.done) r_raw <= div_rsp.quot[RAW_W-1:0];
            default: begin
            end
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_tds_ppm         = r_out_ppm;
    assign o_average_mv      = r_out_avg;
    assign o_sample_rejected = r_out_rej;

`ifndef SYNTHESIS
    a_rej_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rej) |-> (r_out_avg == '0))
        else $error("rejected word reports a nonzero average");

    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_AVG_WAIT || r_state == S_V_WAIT ||
                          r_state == S_RAW_WAIT))
        else $error("divider result arrived outside a wait step");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_SUM || r_state == S_SQ))
        else $error("accepted word did not start the sequence");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(AVG_DEPTH))
        else $error("nonzero entry count exceeds ring depth");
`endif

endmodule

`default_nettype wire

### hw/rtl/tdsac_div.sv
// Restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module tdsac_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tdsac_pkg::t_div_req i_req,
    output tdsac_pkg::t_div_rsp     o_rsp
);
    import tdsac_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DW-1:0]    r_rem;
    logic [DIV_NW-1:0]    r_quot;
    logic [DIV_DW-1:0]    r_den;

    logic [DIV_DW:0] rem_sh;
    logic [DIV_DW:0] diff;
    logic            fits;

    assign rem_sh = {r_rem, r_quot[DIV_NW-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign fits   = !diff[DIV_DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(DIV_NW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quot <= i_req.num;
            r_den  <= i_req.den;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_rem  <= fits ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            r_quot <= {r_quot[DIV_NW-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted mid-division");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a division in progress");
`endif

endmodule

`default_nettype wire
